[hw/rtl/lpc_pkg.sv]
// Shared types, constants and channel helpers for the lightmap pixel compositor.
`default_nettype none

package lpc_pkg;

    localparam int SRC_W      = 3;
    localparam int RAW_W      = 16;
    localparam int CHAN_W     = 8;
    localparam int GAIN_W     = 9;
    localparam int SUM_W      = 11;
    localparam int PACKED_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int FIELD_W    = 5;

    typedef logic [SRC_W-1:0]      src_idx_t;
    typedef logic [RAW_W-1:0]      raw_pix_t;
    typedef logic [CHAN_W-1:0]     chan_t;
    typedef logic [GAIN_W-1:0]     gain_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [PACKED_W-1:0]   packed_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam logic     FMT_GRAY    = 1'b0;
    localparam logic     FMT_XBGR555 = 1'b1;
    localparam src_idx_t SRC_STATIC  = 3'd0;
    localparam cfg_idx_t REG_SOURCE_FORMAT = 3'd0;
    localparam gain_t    GAIN_ONE    = 9'd256;
    localparam chan_t    CHAN_MAX    = 8'd255;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    typedef struct packed {
        logic  source_format;
        gain_t gain;
    } lpc_cfg_t;

    function automatic rgb_t decode_pixel(input logic fmt, input raw_pix_t pix);
        rgb_t c;
        if (fmt == FMT_GRAY) begin
            c.red   = pix[7:0];
            c.green = pix[7:0];
            c.blue  = pix[7:0];
        end
        else begin
            c.red   = {pix[FIELD_W-1:0], 3'b000};
            c.green = {pix[2*FIELD_W-1:FIELD_W], 3'b000};
            c.blue  = {pix[3*FIELD_W-1:2*FIELD_W], 3'b000};
        end
        return c;
    endfunction

    function automatic gain_t scale_chan(input gain_t gain, input chan_t chan);
        logic [GAIN_W+CHAN_W-1:0] p;
        p = (GAIN_W + CHAN_W)'(gain) * (GAIN_W + CHAN_W)'(chan);
        return p[GAIN_W+CHAN_W-1:CHAN_W];
    endfunction

    function automatic chan_t sat8(input sum_t v);
        return (v > SUM_W'(CHAN_MAX)) ? CHAN_MAX : v[CHAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lpc_if.sv]
// Stream interfaces for source pixel beats and composited pixel beats.
`default_nettype none

interface lpc_in_if
    import lpc_pkg::*;
;
    logic     valid;
    logic     ready;
    src_idx_t source_index;
    raw_pix_t raw_pixel;
    logic     last_of_pixel;

    modport source (output valid, output source_index, output raw_pixel,
                    output last_of_pixel, input ready);
    modport sink   (input valid, input source_index, input raw_pixel,
                    input last_of_pixel, output ready);
endinterface

interface lpc_out_if
    import lpc_pkg::*;
;
    logic    valid;
    logic    ready;
    packed_t packed_pixel;

    modport source (output valid, output packed_pixel, input ready);
    modport sink   (input valid, input packed_pixel, output ready);
endinterface

`default_nettype wire

[hw/rtl/lpc_config.sv]
// Configuration registers: source format and per-light gains with gain selection.
`default_nettype none

module lpc_config
    import lpc_pkg::*;
#(
    parameter int LIGHT_COUNT = 7
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_write,
    input  wire cfg_idx_t  cfg_index,
    input  wire cfg_data_t cfg_data,
    input  wire src_idx_t  src_sel,
    output lpc_cfg_t       cfg
);

    logic  format_reg;
    gain_t gain_reg [1:LIGHT_COUNT];
    gain_t gain_clamped;

    assign gain_clamped = (cfg_data > GAIN_ONE) ? GAIN_ONE : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_XBGR555;
            for (int i = 1; i <= LIGHT_COUNT; i++)
            begin
                gain_reg[i] <= GAIN_ONE;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_SOURCE_FORMAT)
            begin
                format_reg <= cfg_data[0];
            end
            for (int i = 1; i <= LIGHT_COUNT; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    gain_reg[i] <= gain_clamped;
                end
            end
        end
    end

    // A source index outside the light range selects a gain of zero.
    always_comb
    begin
        cfg.source_format = format_reg;
        cfg.gain          = '0;
        for (int i = 1; i <= LIGHT_COUNT; i++)
        begin
            if (src_sel == SRC_W'(i))
            begin
                cfg.gain = gain_reg[i];
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lpc_accum.sv]
// Input register, per-channel scale and accumulate, saturation and result register.
`default_nettype none

module lpc_accum
    import lpc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    lpc_in_if.sink        source,
    lpc_out_if.source     result,
    input  wire lpc_cfg_t cfg,
    output src_idx_t      src_sel
);

    logic     s1_valid_reg;
    src_idx_t s1_src_reg;
    raw_pix_t s1_pix_reg;
    logic     s1_last_reg;

    sum_t sum_red_reg, sum_green_reg, sum_blue_reg;
    sum_t sum_red_next, sum_green_next, sum_blue_next;

    logic    out_valid_reg;
    packed_t out_pixel_reg;

    logic out_free;
    logic fire;
    rgb_t chan;

    assign out_free     = !out_valid_reg || result.ready;
    assign fire         = s1_valid_reg && (!s1_last_reg || out_free);
    assign source.ready = !s1_valid_reg || fire;
    assign src_sel      = s1_src_reg;

    assign result.valid        = out_valid_reg;
    assign result.packed_pixel = out_pixel_reg;

    assign chan = decode_pixel(cfg.source_format, s1_pix_reg);

    always_comb
    begin
        if (s1_src_reg == SRC_STATIC)
        begin
            sum_red_next   = SUM_W'(chan.red);
            sum_green_next = SUM_W'(chan.green);
            sum_blue_next  = SUM_W'(chan.blue);
        end
        else
        begin
            sum_red_next   = SUM_W'(sum_red_reg + SUM_W'(scale_chan(cfg.gain, chan.red)));
            sum_green_next = SUM_W'(sum_green_reg + SUM_W'(scale_chan(cfg.gain, chan.green)));
            sum_blue_next  = SUM_W'(sum_blue_reg + SUM_W'(scale_chan(cfg.gain, chan.blue)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
        end
        else
        begin
            if (source.ready)
            begin
                s1_valid_reg <= source.valid;
            end
            if (fire && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                if (s1_last_reg)
                begin
                    sum_red_reg   <= '0;
                    sum_green_reg <= '0;
                    sum_blue_reg  <= '0;
                end
                else
                begin
                    sum_red_reg   <= sum_red_next;
                    sum_green_reg <= sum_green_next;
                    sum_blue_reg  <= sum_blue_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (source.ready && source.valid)
        begin
            s1_src_reg  <= source.source_index;
            s1_pix_reg  <= source.raw_pixel;
            s1_last_reg <= source.last_of_pixel;
        end
        if (fire && s1_last_reg)
        begin
            out_pixel_reg <= {sat8(sum_red_next), sat8(sum_green_next), sat8(sum_blue_next)};
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lightmap_pixel_composite_unit.sv]
// Lightmap pixel compositor top level: configuration registers and accumulate datapath.
//
// Source pixel beats arrive on the source channel, one per light source of a pixel;
// the beat marked last_of_pixel closes the pixel and yields one beat on the result
// channel, packed as red, green, blue bytes. Source 0 loads the channel sums, and
// lights 1 to LIGHT_COUNT add their gain-scaled channels; other indexes add nothing.
// The configuration port writes the format and gain registers; the user must see that it
// is written only while the block holds no beat, as the block does not enforce this.
// Throughput is one source beat per cycle, but a closing beat waits while the result
// register is stalled. Each beat is registered on entry; from the input register one
// 9x8 multiply and an 11-bit add per channel update the sums.
// A stalled result register keeps its beat; the input register still takes one more
// source beat, and beats that do not close a pixel keep flowing. A closing beat waits
// in the input register until the result register frees up.
// Reset clears the sums and both valid flags, sets the format to xBGR 5-5-5 and all
// gains to 1.0.
`default_nettype none

module lightmap_pixel_composite_unit
    import lpc_pkg::*;
#(
    parameter int LIGHT_COUNT = 7
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_write,
    input  wire cfg_idx_t  cfg_index,
    input  wire cfg_data_t cfg_data,
    lpc_in_if.sink         source,
    lpc_out_if.source      result
);

    lpc_cfg_t cfg;
    src_idx_t src_sel;

    lpc_config #(
        .LIGHT_COUNT(LIGHT_COUNT)
    ) u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_sel   (src_sel),
        .cfg       (cfg)
    );

    lpc_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .source  (source),
        .result  (result),
        .cfg     (cfg),
        .src_sel (src_sel)
    );

endmodule

`default_nettype wire

[hw/rtl/lpc_checker.sv]
// Port-level checks for the lightmap pixel compositor and their bind.
`default_nettype none

module lpc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic src_valid,
    input wire logic src_ready,
    input wire logic src_last,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic [23:0] res_pixel
);

    // A result beat that is not taken stays offered with the same pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_pixel))
        else $error("result beat dropped or changed while stalled");

    // With the result register empty, the block always takes a source beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> src_ready)
        else $error("source stalled with empty result register");

    // A new result beat is offered only after an accepted closing source beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(src_valid && src_ready && src_last, 2))
        else $error("result beat without a closing source beat");

endmodule

bind lightmap_pixel_composite_unit lpc_checker u_lpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (source.valid),
    .src_ready (source.ready),
    .src_last  (source.last_of_pixel),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_pixel (result.packed_pixel)
);

`default_nettype wire

[verif/tb_lightmap_pixel_composite_unit.sv]
// Testbench for the lightmap pixel compositor: random source beats checked by a local predictor.
module tb_lightmap_pixel_composite_unit
    import lpc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       LIGHTS      = 7;
    localparam int       HOLD_CYCLES = 300;
    localparam int       SETTLE      = 8;
    localparam int       CYCLE_LIMIT = 100000;
    localparam int       PHASE_BEATS = 360;
    localparam cfg_idx_t REG_GAIN_LIGHT_1 = 3'd1;

    typedef struct {
        src_idx_t src;
        raw_pix_t pix;
        logic     last;
    } source_beat_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_write;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    lpc_in_if  src_ch ();
    lpc_out_if res_ch ();

    lightmap_pixel_composite_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .source    (src_ch),
        .result    (res_ch)
    );

    source_beat_t pending_beats[$];
    packed_t      expected_pixels[$];
    source_beat_t beat_next;
    packed_t      pixel_expected;

    logic  model_fmt;
    gain_t model_gain[1:LIGHTS];
    sum_t  model_sums[3];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          beats_accepted = 0;
    int          pixels_checked = 0;
    int          mismatches = 0;
    int          hold_count = 0;
    logic        hold_trigger = 1'b0;
    logic        rx_hold = 1'b0;
    int unsigned cycle_count = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void apply_reg(cfg_idx_t idx, cfg_data_t d);
        if (idx == REG_SOURCE_FORMAT)
        begin
            model_fmt = d[0];
        end
        else
        begin
            model_gain[idx] = (d > GAIN_ONE) ? GAIN_ONE : gain_t'(d);
        end
    endfunction

    function automatic void composite_beat(source_beat_t b);
        chan_t        ch[3];
        logic [16:0]  prod;
        chan_t        sat[3];
        if (model_fmt == FMT_GRAY)
        begin
            ch[0] = b.pix[7:0];
            ch[1] = b.pix[7:0];
            ch[2] = b.pix[7:0];
        end
        else
        begin
            ch[0] = {b.pix[4:0], 3'b000};
            ch[1] = {b.pix[9:5], 3'b000};
            ch[2] = {b.pix[14:10], 3'b000};
        end
        for (int k = 0; k < 3; k++)
        begin
            if (b.src == SRC_STATIC)
            begin
                model_sums[k] = sum_t'(ch[k]);
            end
            else if (b.src <= LIGHTS)
            begin
                prod = model_gain[b.src] * ch[k];
                model_sums[k] = model_sums[k] + sum_t'(prod[16:8]);
            end
        end
        if (b.last)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sat[k] = (model_sums[k] > sum_t'(CHAN_MAX)) ? CHAN_MAX : model_sums[k][7:0];
                model_sums[k] = '0;
            end
            expected_pixels.insert(expected_pixels.size(), {sat[0], sat[1], sat[2]});
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_ch.valid         <= 1'b0;
            src_ch.source_index  <= '0;
            src_ch.raw_pixel     <= '0;
            src_ch.last_of_pixel <= 1'b0;
        end
        else
        begin
            if (src_ch.valid && src_ch.ready)
            begin
                composite_beat('{src: src_ch.source_index, pix: src_ch.raw_pixel,
                                 last: src_ch.last_of_pixel});
                beats_accepted++;
            end
            if (!src_ch.valid || src_ch.ready)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat_next = pending_beats.pop_front();
                    src_ch.valid         <= 1'b1;
                    src_ch.source_index  <= beat_next.src;
                    src_ch.raw_pixel     <= beat_next.pix;
                    src_ch.last_of_pixel <= beat_next.last;
                end
                else
                begin
                    src_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: pixel mismatch, expected none, actual 0x%06h",
                             $time, res_ch.packed_pixel);
                    mismatches++;
                end
                else
                begin
                    pixel_expected = expected_pixels.pop_front();
                    if (res_ch.packed_pixel !== pixel_expected)
                    begin
                        $display("%0t: pixel mismatch, expected 0x%06h, actual 0x%06h",
                                 $time, pixel_expected, res_ch.packed_pixel);
                        mismatches++;
                    end
                    pixels_checked++;
                end
            end
            res_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The long receiver hold lets the block fill up while the source keeps offering beats.
    always @(posedge clk)
    begin
        if (hold_trigger && hold_count < HOLD_CYCLES)
        begin
            rx_hold    <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            rx_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d pixels outstanding",
                     cycle_count, expected_pixels.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, cfg_data_t d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        apply_reg(idx, d);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic push_beat(src_idx_t s, raw_pix_t p, logic l);
        pending_beats.insert(pending_beats.size(), '{src: s, pix: p, last: l});
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || src_ch.valid || expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic randomize_regs();
        cfg_data_t g;
        write_reg(REG_SOURCE_FORMAT, cfg_data_t'($urandom_range(0, 1)));
        for (int k = 1; k <= LIGHTS; k++)
        begin
            case ($urandom_range(0, 5))
                0:       g = '0;
                1:       g = cfg_data_t'(GAIN_ONE);
                2:       g = cfg_data_t'($urandom_range(257, 511));
                default: g = cfg_data_t'($urandom_range(0, 256));
            endcase
            write_reg(cfg_idx_t'(REG_GAIN_LIGHT_1 + k - 1), g);
        end
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int beats, logic with_hold);
        int n;
        int lights;
        n = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        randomize_regs();
        while (n < beats)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                lights = $urandom_range(0, LIGHTS);
                push_beat(SRC_STATIC, raw_pix_t'($urandom), lights == 0);
                for (int j = 1; j <= lights; j++)
                begin
                    push_beat(src_idx_t'($urandom_range(1, LIGHTS)), raw_pix_t'($urandom),
                              j == lights);
                end
                n += lights + 1;
            end
            else
            begin
                push_beat(src_idx_t'($urandom), raw_pix_t'($urandom), $urandom_range(0, 3) == 0);
                n++;
            end
        end
        if (with_hold)
        begin
            hold_trigger <= 1'b1;
        end
        wait_drained();
    endtask

    initial
    begin
        cfg_data_t first_gains[LIGHTS];
        first_gains = '{256, 0, 511, 257, 1, 128, 255};
        src_ch.valid         = 1'b0;
        src_ch.source_index  = '0;
        src_ch.raw_pixel     = '0;
        src_ch.last_of_pixel = 1'b0;
        res_ch.ready         = 1'b0;
        cfg_write            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        model_fmt            = FMT_XBGR555;
        for (int k = 1; k <= LIGHTS; k++)
        begin
            model_gain[k] = GAIN_ONE;
        end
        for (int k = 0; k < 3; k++)
        begin
            model_sums[k] = '0;
        end
        send_idle_pct = 15;
        recv_idle_pct = 62;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_SOURCE_FORMAT, cfg_data_t'(FMT_XBGR555));
        for (int k = 1; k <= LIGHTS; k++)
        begin
            write_reg(cfg_idx_t'(REG_GAIN_LIGHT_1 + k - 1), first_gains[k-1]);
        end
        push_beat(SRC_STATIC, 16'h0000, 1'b1);
        push_beat(SRC_STATIC, 16'hffff, 1'b1);
        push_beat(SRC_STATIC, 16'h001f, 1'b0);
        push_beat(3'd1, 16'h7fff, 1'b0);
        push_beat(3'd2, 16'h7fff, 1'b0);
        push_beat(3'd3, 16'h7fff, 1'b0);
        push_beat(3'd4, 16'h03e0, 1'b0);
        push_beat(3'd5, 16'h7c00, 1'b0);
        push_beat(3'd6, 16'h7fff, 1'b0);
        push_beat(3'd7, 16'h7fff, 1'b1);
        push_beat(3'd3, 16'h1234, 1'b1);
        push_beat(SRC_STATIC, 16'h7fff, 1'b0);
        push_beat(SRC_STATIC, 16'h0421, 1'b1);
        wait_drained();

        write_reg(REG_SOURCE_FORMAT, cfg_data_t'(FMT_GRAY));
        for (int k = 1; k <= LIGHTS; k++)
        begin
            write_reg(cfg_idx_t'(REG_GAIN_LIGHT_1 + k - 1), cfg_data_t'(GAIN_ONE));
        end
        push_beat(SRC_STATIC, 16'hff00, 1'b1);
        push_beat(SRC_STATIC, 16'h00ff, 1'b0);
        push_beat(3'd1, 16'h00ff, 1'b0);
        push_beat(3'd2, 16'h80ff, 1'b0);
        push_beat(3'd7, 16'hffff, 1'b0);
        push_beat(3'd5, 16'h00ff, 1'b1);
        push_beat(3'd4, 16'hab80, 1'b0);
        push_beat(SRC_STATIC, 16'h0001, 1'b1);
        push_beat(3'd6, 16'h1234, 1'b1);
        wait_drained();

        run_phase(15, 62, PHASE_BEATS, 1'b0);
        run_phase(62, 15, PHASE_BEATS, 1'b0);
        run_phase(0, 0, PHASE_BEATS, 1'b1);

        $display("Accepted %0d source beats and checked %0d composited pixels.",
                 beats_accepted, pixels_checked);
        $display("Both source formats, gains over the full range and a %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (mismatches == 0 && expected_pixels.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lpc_pkg.sv
hw/rtl/lpc_if.sv
hw/rtl/lpc_config.sv
hw/rtl/lpc_accum.sv
hw/rtl/lightmap_pixel_composite_unit.sv
hw/rtl/lpc_checker.sv
verif/tb_lightmap_pixel_composite_unit.sv
